// ===== src/cacm_pkg.sv =====
// Package for the crank angle cadence meter.
// Types, state codes and fixed constants shared by controller, datapath and top level.
// No dependencies.
`default_nettype none

package cacm_pkg;

	localparam int ANGLE_W   = 16;
	localparam int CAD_W     = 16;
	localparam int ADV_W     = 18;   // signed advance, covers wrapped and negative cases
	localparam int PROD_W    = 28;   // signed advance * 500
	localparam int MHI_W     = 48;   // bits 63:16 of the 64-bit scaled advance
	localparam int QUO_W     = 16;   // quotient bits produced by the divider
	localparam int DIV_STEPS = 16;
	localparam int STEP_W    = 4;

	localparam logic [ANGLE_W-1:0] THR_RESET  = 16'd3000;
	localparam logic [ADV_W-1:0]   FULL_TURN  = 18'd36000;
	localparam logic [CAD_W-1:0]   CAD_MAX    = 16'hFFFF;
	localparam logic signed [PROD_W-1:0] ADV_SCALE = 28'sd500;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_EVAL  = 5'b00010,
		ST_SAT   = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_WRITE = 5'b10000
	} cacm_state_t;

	typedef struct packed {
		logic load_in;
		logic eval;
		logic sat_chk;
		logic div_step;
		logic write;
	} cacm_cmd_t;

	typedef struct packed {
		logic upd;
		logic out_free;
	} cacm_stat_t;

endpackage

`default_nettype wire

// ===== src/cacm_ctrl.sv =====
// Controller of the crank angle cadence meter: one-hot sequencer and divide step counter.
// Depends on cacm_pkg.
`default_nettype none

module cacm_ctrl
	import cacm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  cacm_stat_t stat,
	output cacm_cmd_t  cmd
);

	cacm_state_t state_q, state_d;
	logic [STEP_W-1:0] cnt_q;
	logic last_step;

	assign last_step = (cnt_q == STEP_W'(DIV_STEPS - 1));
	assign in_ready  = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_SAT;
			end
			ST_SAT: begin
				cmd.sat_chk = 1'b1;
				state_d     = stat.upd ? ST_DIV : ST_WRITE;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (last_step) state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (stat.out_free) begin
					cmd.write = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) cnt_q <= cnt_q + 1'b1;
			else                   cnt_q <= '0;
		end
	end

`ifndef SYNTHESIS
	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_EVAL)
		else $error("accepted request did not start evaluation");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && last_step |=> state_q == ST_WRITE)
		else $error("divider did not finish after its step count");
`endif

endmodule

`default_nettype wire

// ===== src/cacm_dp.sv =====
// Datapath of the crank angle cadence meter: reference state, advance and interval,
// restoring divider for advance*500/(3*elapsed), output register. Depends on cacm_pkg.
`default_nettype none

module cacm_dp
	import cacm_pkg::*;
#(
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cacm_cmd_t            cmd,
	output cacm_stat_t           stat,
	input  logic                 cfg_valid,
	input  logic [ANGLE_W-1:0]   advance_threshold,
	input  logic                 first_sample,
	input  logic [ANGLE_W-1:0]   crank_angle,
	input  logic [TIME_BITS-1:0] time_ms,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CAD_W-1:0]     cadence,
	output logic                 updated
);

	localparam int DW = TIME_BITS + 2;
	localparam int CW = (DW > MHI_W) ? DW : MHI_W;

	logic [ANGLE_W-1:0]   thr_q;
	logic [ANGLE_W-1:0]   ref_angle_q;
	logic [TIME_BITS-1:0] ref_time_q;
	logic [CAD_W-1:0]     held_q;

	logic                 first_q;
	logic [ANGLE_W-1:0]   angle_q;
	logic [TIME_BITS-1:0] time_q;

	logic [MHI_W-1:0] mhi_q;
	logic [QUO_W-1:0] mlo_q;
	logic [DW-1:0]    dvs_q;
	logic             upd_q;
	logic             sat_q;
	logic [DW-1:0]    rem_q;
	logic [QUO_W-1:0] quo_q;

	logic                 out_valid_q;
	logic [CAD_W-1:0]     out_cad_q;
	logic                 out_upd_q;

	logic [ADV_W-1:0]        adv;
	logic                    take;
	logic signed [PROD_W-1:0] prod;
	logic [TIME_BITS-1:0]    elapsed;
	logic [DW-1:0]           dvs_next;
	logic [CW-1:0]           mhi_ext;
	logic [CW-1:0]           dvs_ext;
	logic [DW:0]             trial;
	logic [DW:0]             diff;
	logic                    ge;
	logic [CAD_W-1:0]        result;

	always_comb begin
		if (angle_q > ref_angle_q)
			adv = {2'b00, angle_q} - {2'b00, ref_angle_q};
		else if (angle_q == ref_angle_q)
			adv = '0;
		else
			adv = {2'b00, angle_q} + FULL_TURN - {2'b00, ref_angle_q};
	end

	assign take     = adv[ADV_W-1] || (adv[ADV_W-2:0] >= {1'b0, thr_q});
	assign prod     = $signed({{(PROD_W-ADV_W){adv[ADV_W-1]}}, adv}) * ADV_SCALE;
	assign elapsed  = time_q - ref_time_q;
	assign dvs_next = {2'b00, elapsed} + {1'b0, elapsed, 1'b0};

	assign mhi_ext = CW'(mhi_q);
	assign dvs_ext = CW'(dvs_q);

	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	assign result = !upd_q ? held_q : (sat_q ? CAD_MAX : quo_q);

	assign stat.upd      = upd_q;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign cadence   = out_cad_q;
	assign updated   = out_upd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= THR_RESET;
			ref_angle_q <= '0;
			ref_time_q  <= '0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) thr_q <= advance_threshold;
			if (cmd.write) begin
				out_valid_q <= 1'b1;
				if (first_q || upd_q) begin
					ref_angle_q <= angle_q;
					ref_time_q  <= time_q;
				end
				if (upd_q) held_q <= result;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			first_q <= first_sample;
			angle_q <= crank_angle;
			time_q  <= time_ms;
		end
		if (cmd.eval) begin
			mhi_q <= {{(MHI_W-(PROD_W-QUO_W)){prod[PROD_W-1]}}, prod[PROD_W-1:QUO_W]};
			mlo_q <= prod[QUO_W-1:0];
			dvs_q <= dvs_next;
			upd_q <= take && !first_q;
		end
		if (cmd.sat_chk) begin
			sat_q <= (mhi_ext >= dvs_ext);
			rem_q <= mhi_ext[DW-1:0];
			quo_q <= mlo_q;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
		if (cmd.write) begin
			out_cad_q <= result;
			out_upd_q <= upd_q;
		end
	end

`ifndef SYNTHESIS
	a_held_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |=> held_q == out_cad_q)
		else $error("held cadence and delivered cadence differ");
	a_zero_interval: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sat_chk && dvs_q == '0 |=> sat_q)
		else $error("zero interval did not saturate");
	a_no_update_first: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write && first_q |=> !out_upd_q)
		else $error("first sample flagged as update");
`endif

endmodule

`default_nettype wire

// ===== src/crank_angle_cadence_meter_core.sv =====
// Top level of the crank angle cadence meter: controller plus datapath.
// Depends on cacm_pkg, cacm_ctrl, cacm_dp.
//
// channel  | handshake             | payload
// ---------+-----------------------+-----------------------------------------
// input    | in_valid / in_ready   | first_sample, crank_angle, time_ms
// output   | out_valid / out_ready | cadence, updated
// config   | cfg_valid / cfg_ready | advance_threshold
//
// An item runs idle, eval, sat and write when only the reference moves or the
// threshold is not reached, and div as well when a cadence is computed: the
// 16 quotient bits come from a one-bit-per-cycle restoring divider. A finished
// result sits in the output register, and the next request is taken while it
// waits; an item stalls in write only while the previous result is still held.
// Reset clears the reference angle, time and held cadence, threshold to 3000.
`default_nettype none

module crank_angle_cadence_meter_core
	import cacm_pkg::*;
#(
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 first_sample,
	input  logic [ANGLE_W-1:0]   crank_angle,
	input  logic [TIME_BITS-1:0] time_ms,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CAD_W-1:0]     cadence,
	output logic                 updated,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [ANGLE_W-1:0]   advance_threshold
);

	cacm_cmd_t  cmd;
	cacm_stat_t stat;

	assign cfg_ready = 1'b1;

	cacm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cacm_dp #(
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.cfg_valid         (cfg_valid),
		.advance_threshold (advance_threshold),
		.first_sample      (first_sample),
		.crank_angle       (crank_angle),
		.time_ms           (time_ms),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.cadence           (cadence),
		.updated           (updated)
	);

endmodule

`default_nettype wire

// ===== sim/tb_crank_angle_cadence_meter_core.sv =====
// Testbench for crank_angle_cadence_meter_core: a queue-fed driver and a clocked monitor that
// checks every reading against a cycle-free predictor of the cadence arithmetic.
// Depends on cacm_pkg and the RTL of the core.

module tb_crank_angle_cadence_meter_core;
	timeunit 1ns;
	timeprecision 1ps;

	import cacm_pkg::*;

	localparam int STAMP_W = 32;

	typedef struct {
		logic               first;
		logic [ANGLE_W-1:0] angle;
		logic [STAMP_W-1:0] stamp;
	} sample_t;

	typedef struct {
		logic [CAD_W-1:0] cadence;
		logic             updated;
	} reading_t;

	typedef enum int {PACE_FULL, PACE_SRC_IDLE, PACE_SINK_STALL, PACE_BOTH} pace_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 first_sample = 1'b0;
	logic [ANGLE_W-1:0]   crank_angle = '0;
	logic [STAMP_W-1:0]   time_ms = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [CAD_W-1:0]     cadence;
	logic                 updated;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [ANGLE_W-1:0]   advance_threshold = '0;

	sample_t  sample_q[$];
	reading_t reading_q[$];
	int       sent_cnt = 0;
	int       acc_cnt = 0;
	int       n_err = 0;
	pace_t    pace = PACE_FULL;

	// predictor state
	logic [ANGLE_W-1:0] m_thr = 16'd3000;
	logic [ANGLE_W-1:0] m_ref_angle = '0;
	logic [STAMP_W-1:0] m_ref_stamp = '0;
	logic [CAD_W-1:0]   m_held = '0;

	crank_angle_cadence_meter_core #(.TIME_BITS(STAMP_W)) dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.first_sample      (first_sample),
		.crank_angle       (crank_angle),
		.time_ms           (time_ms),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.cadence           (cadence),
		.updated           (updated),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.advance_threshold (advance_threshold)
	);

	// 64-bit wrapping arithmetic on purpose: out-of-range angles give huge advances
	function automatic reading_t predict_reading(logic first, logic [ANGLE_W-1:0] angle,
			logic [STAMP_W-1:0] stamp);
		bit [63:0]          adv;
		bit [63:0]          elapsed;
		bit [63:0]          quo;
		logic [STAMP_W-1:0] dt;
		reading_t           r;
		r.updated = 1'b0;
		if (first) begin
			m_ref_angle = angle;
			m_ref_stamp = stamp;
		end else begin
			if (angle > m_ref_angle)
				adv = 64'(angle) - 64'(m_ref_angle);
			else if (angle == m_ref_angle)
				adv = 64'd0;
			else
				adv = 64'(angle) + 64'd36000 - 64'(m_ref_angle);
			if (adv >= 64'(m_thr)) begin
				dt = stamp - m_ref_stamp;
				elapsed = 64'(dt);
				if (elapsed == 64'd0) begin
					quo = 64'd65535;
				end else begin
					quo = ((adv * 64'd500) / 64'd3) / elapsed;
					if (quo > 64'd65535)
						quo = 64'd65535;
				end
				m_held = quo[CAD_W-1:0];
				m_ref_angle = angle;
				m_ref_stamp = stamp;
				r.updated = 1'b1;
			end
		end
		r.cadence = m_held;
		return r;
	endfunction

	function automatic bit skip_cycle(bit sink);
		case (pace)
			PACE_SRC_IDLE:   return !sink && ($urandom_range(99) < 81);
			PACE_SINK_STALL: return sink && ($urandom_range(99) < 81);
			PACE_BOTH:       return $urandom_range(99) < 23;
			default:         return 1'b0;
		endcase
	endfunction

	task automatic push_sample(logic first, logic [ANGLE_W-1:0] angle, logic [STAMP_W-1:0] stamp);
		sample_t s;
		s.first = first;
		s.angle = angle;
		s.stamp = stamp;
		sample_q.push_back(s);
	endtask

	// mostly plausible rotation sequences, some restarts and full-range noise
	task automatic add_random(int n);
		int                 sel;
		int                 a;
		logic [STAMP_W-1:0] t;
		a = $urandom_range(35999);
		t = $urandom;
		push_sample(1'b1, ANGLE_W'(a), t);
		for (int k = 1; k < n; k++) begin
			sel = $urandom_range(99);
			if (sel < 8) begin
				a = $urandom_range(35999);
				t = t + $urandom_range(50);
				push_sample(1'b1, ANGLE_W'(a), t);
			end else if (sel < 18) begin
				push_sample(1'($urandom_range(1)), ANGLE_W'($urandom), $urandom);
			end else begin
				a = (a + $urandom_range(9000)) % 36000;
				if ($urandom_range(19) == 0)
					t = t + $urandom;
				else
					t = t + $urandom_range(300);
				push_sample(1'b0, ANGLE_W'(a), t);
			end
		end
	endtask

	task automatic drain();
		while (sample_q.size() != 0 || acc_cnt != sent_cnt || reading_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_threshold(logic [ANGLE_W-1:0] v);
		@(negedge clk);
		advance_threshold <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin : drive_samples
		sample_t s;
		if (arst_n) begin
			if (in_valid && acc_cnt != sent_cnt) begin
				// hold request until taken
			end else if (sample_q.size() != 0 && !skip_cycle(1'b0)) begin
				s = sample_q.pop_front();
				in_valid <= 1'b1;
				first_sample <= s.first;
				crank_angle <= s.angle;
				time_ms <= s.stamp;
				sent_cnt <= sent_cnt + 1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		out_ready <= arst_n && !skip_cycle(1'b1);
	end

	always @(posedge clk) begin : watch
		reading_t e;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				m_thr = advance_threshold;
			if (in_valid && in_ready) begin
				reading_q.push_back(predict_reading(first_sample, crank_angle, time_ms));
				acc_cnt <= acc_cnt + 1;
			end
			if (out_valid && out_ready) begin
				if (reading_q.size() == 0) begin
					$error("unexpected reading: cadence %0d updated %0b", cadence, updated);
					n_err++;
				end else begin
					e = reading_q.pop_front();
					if (cadence !== e.cadence) begin
						$error("cadence: expected %0d, actual %0d", e.cadence, cadence);
						n_err++;
					end
					if (updated !== e.updated) begin
						$error("updated: expected %0b, actual %0b", e.updated, updated);
						n_err++;
					end
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset threshold 3000
		push_sample(1'b0, 16'd5000, 32'd100);
		push_sample(1'b1, 16'd0, 32'd0);
		push_sample(1'b0, 16'd1000, 32'd10);
		push_sample(1'b0, 16'd35999, 32'd20);
		push_sample(1'b0, 16'd100, 32'd30);
		push_sample(1'b0, 16'd3500, 32'd40);
		push_sample(1'b1, 16'd0, 32'd1000);
		push_sample(1'b0, 16'd5000, 32'd1000);
		push_sample(1'b0, 16'd8000, 32'd1001);
		push_sample(1'b1, 16'd0, 32'hFFFF_FFF0);
		push_sample(1'b0, 16'd4000, 32'h0000_0010);
		push_sample(1'b1, 16'd0, 32'd0);
		push_sample(1'b0, 16'd30000, 32'hFFFF_FFFF);
		push_sample(1'b1, 16'hFFFF, 32'd50);
		push_sample(1'b0, 16'd0, 32'd60);
		push_sample(1'b0, 16'hFFFF, 32'd70);
		push_sample(1'b1, 16'd40000, 32'h8000_0000);
		push_sample(1'b0, 16'd50000, 32'h8000_0400);
		drain();

		write_threshold(16'd0);
		push_sample(1'b1, 16'd1234, 32'd5);
		push_sample(1'b0, 16'd1234, 32'd10);
		push_sample(1'b0, 16'd1234, 32'd10);
		add_random(100);
		drain();

		write_threshold(16'd35999);
		pace = PACE_SRC_IDLE;
		add_random(100);
		drain();

		write_threshold(16'hFFFF);
		pace = PACE_SINK_STALL;
		add_random(100);
		drain();

		write_threshold(ANGLE_W'($urandom_range(35999)));
		pace = PACE_BOTH;
		add_random(100);
		drain();

		write_threshold(16'd1);
		pace = PACE_FULL;
		add_random(100);
		drain();

		if (n_err == 0 && reading_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
